### rtl/sdtp_pkg.sv
package sdtp_pkg;

  localparam logic [7:0] TAG_SERVICE      = 8'h48;
  localparam logic [7:0] DEFAULT_TID      = 8'h42;
  localparam logic [5:0] NAME_CAP         = 6'd50;
  localparam logic [3:0] LEN_HI_MASK      = 4'hF;

  localparam logic CFG_TID        = 1'b0;
  localparam logic CFG_NAME_LIMIT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_END    = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_HEADER = 3'd3,
    PH_SVC    = 3'd4,
    PH_DTAG   = 3'd5,
    PH_DLEN   = 3'd6,
    PH_DBODY  = 3'd7
  } phase_e;

  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  service_ident;
    logic [15:0]  network_ident;
    logic [15:0]  stream_ident;
    logic [2:0]   kind_code;
    logic [7:0]   tag_seen;
    logic [7:0]   name_char;
    logic [5:0]   name_length;
    logic [7:0]   service_count;
    logic         last_of_run;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } result_pair_t;

  function automatic logic [2:0] map_kind(input logic [7:0] svc_type);
    logic [2:0] code;
    unique case (svc_type)
      8'h01:   code = 3'd1;
      8'h02:   code = 3'd2;
      8'h0c:   code = 3'd3;
      8'h04:   code = 3'd4;
      8'h05:   code = 3'd5;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

### rtl/sdt_service_descriptor_parser_top.sv
// SDT section parser.
// Input channel: in_valid_i / in_stall_o carry one section byte per transaction;
// first_byte_i marks the table id byte that opens a section. Sections whose
// table id differs from the programmed id are dropped without results.
// Output channel: out_valid_o / out_stall_i carry one result per transaction:
// a service name byte, a descriptor record, or a section-end count.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 table id,
// 1 name limit); write only while no transaction is in flight.
// Path: an accepted byte is registered, then its results go to the result queue.
// Throughput: one byte per cycle while the queue has room; a byte that yields a
// name byte and a record pushes both. A four-entry result queue parts the two
// sides; the input register stalls once fewer than two queue entries are free.
// Reset: the parser drops bytes until a matching start byte, the queue empties,
// and the registers return to table id 0x42 and name limit 50.
// Stall: when out_stall_i holds, results wait in the queue and in_stall_o
// rises when a byte is held and the queue cannot take two more results.
module sdt_service_descriptor_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  section_byte_i,
  input  logic        first_byte_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] service_ident_o,
  output logic [15:0] network_ident_o,
  output logic [15:0] stream_ident_o,
  output logic [2:0]  kind_code_o,
  output logic [7:0]  tag_seen_o,
  output logic [7:0]  name_char_o,
  output logic [5:0]  name_length_o,
  output logic [7:0]  service_count_o,
  output logic        last_of_run_o
);
  import sdtp_pkg::*;

  logic         in_v_q;
  logic [7:0]   in_byte_q;
  logic         in_first_q;
  logic [7:0]   tid_q;
  logic [5:0]   name_limit_q;
  logic         room;
  logic         step;
  result_pair_t pair;
  result_t      res;

  assign step       = in_v_q && room;
  assign in_stall_o = in_v_q && !room;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= section_byte_i;
      in_first_q <= first_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      tid_q        <= DEFAULT_TID;
      name_limit_q <= NAME_CAP;
    end else begin
      if (!in_stall_o) begin
        in_v_q <= in_valid_i;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TID:        tid_q        <= cfg_data_i;
          CFG_NAME_LIMIT: name_limit_q <= cfg_data_i[5:0];
          default:        tid_q        <= tid_q;
        endcase
      end
    end
  end

  sdtp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte_q),
    .first_i      (in_first_q),
    .tid_i        (tid_q),
    .name_limit_i (name_limit_q),
    .pair_o       (pair)
  );

  sdtp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign result_kind_o   = res.kind;
  assign service_ident_o = res.service_ident;
  assign network_ident_o = res.network_ident;
  assign stream_ident_o  = res.stream_ident;
  assign kind_code_o     = res.kind_code;
  assign tag_seen_o      = res.tag_seen;
  assign name_char_o     = res.name_char;
  assign name_length_o   = res.name_length;
  assign service_count_o = res.service_count;
  assign last_of_run_o   = res.last_of_run;

endmodule

### rtl/sdtp_parse.sv
module sdtp_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  first_i,
  input  logic [7:0]            tid_i,
  input  logic [5:0]            name_limit_i,
  output sdtp_pkg::result_pair_t pair_o
);
  import sdtp_pkg::*;

  phase_e      phase_q, phase_d;
  logic        dropping_q, dropping_d;
  logic [11:0] pos_q, pos_d;
  logic [11:0] seclen_q, seclen_d;
  logic [11:0] loop_q, loop_d;
  logic [7:0]  off_q, off_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  prov_q, prov_d;
  logic [15:0] svc_q, svc_d;
  logic [15:0] net_q, net_d;
  logic [15:0] stream_q, stream_d;
  logic [2:0]  kind_q, kind_d;
  logic [5:0]  kept_q, kept_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] pend_q, pend_d;
  logic [15:0] hsvc_q, hsvc_d;
  logic [5:0]  target_q, target_d;

  logic        name_emit, rec_emit, end_emit;
  logic [5:0]  lim;
  logic [11:0] loop_dec;
  logic [8:0]  off_nx;
  logic [8:0]  pbound;
  logic [11:0] seclen_new;
  result_t     name_r, rec_r, end_r;

  always_comb begin
    phase_d    = phase_q;
    dropping_d = dropping_q;
    pos_d      = pos_q;
    seclen_d   = seclen_q;
    loop_d     = loop_q;
    off_d      = off_q;
    dlen_d     = dlen_q;
    tag_d      = tag_q;
    prov_d     = prov_q;
    svc_d      = svc_q;
    net_d      = net_q;
    stream_d   = stream_q;
    kind_d     = kind_q;
    kept_d     = kept_q;
    count_d    = count_q;
    pend_d     = pend_q;
    hsvc_d     = hsvc_q;
    target_d   = target_q;
    name_emit  = 1'b0;
    rec_emit   = 1'b0;
    end_emit   = 1'b0;
    lim        = (name_limit_i > NAME_CAP) ? NAME_CAP : name_limit_i;
    loop_dec   = (loop_q != 12'd0) ? loop_q - 12'd1 : loop_q;
    off_nx     = {1'b0, off_q} + 9'd1;
    pbound     = 9'd2 + {1'b0, prov_q};
    seclen_new = {seclen_q[11:8], byte_i};

    if (step_i) begin
      if (first_i) begin
        if (byte_i == tid_i) begin
          dropping_d = 1'b0;
          phase_d    = PH_LEN_HI;
          pos_d      = '0;
          seclen_d   = '0;
          count_d    = '0;
          net_d      = '0;
          loop_d     = '0;
          off_d      = '0;
        end else begin
          dropping_d = 1'b1;
          phase_d    = PH_IDLE;
        end
      end else if (!dropping_q) begin
        priority if (phase_q == PH_LEN_HI) begin
          seclen_d = {byte_i[3:0] & LEN_HI_MASK, 8'h00};
          phase_d  = PH_LEN_LO;
        end else if (phase_q == PH_LEN_LO) begin
          seclen_d = seclen_new;
          pos_d    = '0;
          if (seclen_new == 12'd0) begin
            end_emit = 1'b1;
          end else begin
            phase_d = PH_HEADER;
          end
        end else begin
          if ({1'b0, pos_q} + 13'd1 >= {1'b0, seclen_q}) begin
            end_emit = 1'b1;
          end else if ({1'b0, pos_q} + 13'd4 < {1'b0, seclen_q}) begin
            unique case (phase_q)
              PH_HEADER: begin
                priority if (pos_q == 12'd0) begin
                  pend_d = {byte_i, 8'h00};
                end else if (pos_q == 12'd1) begin
                  pend_d = {pend_q[15:8], byte_i};
                end else if (pos_q == 12'd3) begin
                  if (byte_i == 8'h00) stream_d = pend_q;
                end else if (pos_q == 12'd5) begin
                  net_d = {byte_i, 8'h00};
                end else if (pos_q == 12'd6) begin
                  net_d = {net_q[15:8], byte_i};
                end else if (pos_q == 12'd7) begin
                  phase_d = PH_SVC;
                  off_d   = '0;
                end else begin
                  pend_d = pend_q;
                end
              end
              PH_SVC: begin
                priority if (off_q == 8'd0) begin
                  hsvc_d   = {byte_i, 8'h00};
                  svc_d    = '0;
                  kind_d   = '0;
                  kept_d   = '0;
                  target_d = '0;
                end else if (off_q == 8'd1) begin
                  hsvc_d = {hsvc_q[15:8], byte_i};
                end else if (off_q == 8'd3) begin
                  loop_d = {byte_i[3:0] & LEN_HI_MASK, 8'h00};
                end else if (off_q == 8'd4) begin
                  loop_d = {loop_q[11:8], byte_i};
                end else begin
                  hsvc_d = hsvc_q;
                end
                off_d = off_nx[7:0];
                if (off_nx >= 9'd5) begin
                  off_d   = '0;
                  phase_d = (loop_d == 12'd0) ? PH_SVC : PH_DTAG;
                end
              end
              PH_DTAG: begin
                loop_d = loop_dec;
                tag_d  = byte_i;
                if (byte_i == TAG_SERVICE) begin
                  svc_d    = hsvc_q;
                  kind_d   = '0;
                  kept_d   = '0;
                  target_d = '0;
                  prov_d   = '0;
                  if (count_q != 8'hFF) count_d = count_q + 8'd1;
                end
                phase_d = PH_DLEN;
              end
              PH_DLEN: begin
                loop_d = loop_dec;
                dlen_d = byte_i;
                off_d  = '0;
                if (byte_i == 8'd0) begin
                  rec_emit = 1'b1;
                  phase_d  = (loop_dec == 12'd0) ? PH_SVC : PH_DTAG;
                end else begin
                  phase_d = PH_DBODY;
                end
              end
              PH_DBODY: begin
                loop_d = loop_dec;
                if (tag_q == TAG_SERVICE) begin
                  priority if (off_q == 8'd0) begin
                    kind_d = map_kind(byte_i);
                  end else if (off_q == 8'd1) begin
                    prov_d = byte_i;
                  end else if ({1'b0, off_q} == pbound) begin
                    target_d = ({2'b00, lim} > byte_i) ? byte_i[5:0] : lim;
                  end else if ({1'b0, off_q} > pbound && kept_q < target_q) begin
                    kept_d    = kept_q + 6'd1;
                    name_emit = 1'b1;
                  end else begin
                    kept_d = kept_q;
                  end
                end
                off_d = off_nx[7:0];
                if (off_nx >= {1'b0, dlen_q}) begin
                  rec_emit = 1'b1;
                  off_d    = '0;
                  phase_d  = (loop_dec == 12'd0) ? PH_SVC : PH_DTAG;
                end
              end
              default: begin
                phase_d    = PH_IDLE;
                dropping_d = 1'b1;
              end
            endcase
          end
          pos_d = pos_q + 12'd1;
        end
        if (end_emit) begin
          phase_d    = PH_IDLE;
          dropping_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    name_r               = '0;
    name_r.kind          = KIND_NAME;
    name_r.service_ident = svc_d;
    name_r.network_ident = net_d;
    name_r.stream_ident  = stream_d;
    name_r.kind_code     = kind_d;
    name_r.tag_seen      = TAG_SERVICE;
    name_r.name_char     = byte_i;
    name_r.name_length   = kept_d;
    name_r.last_of_run   = !rec_emit;

    rec_r                = '0;
    rec_r.kind           = KIND_RECORD;
    rec_r.service_ident  = svc_d;
    rec_r.network_ident  = net_d;
    rec_r.stream_ident   = stream_d;
    rec_r.kind_code      = kind_d;
    rec_r.tag_seen       = tag_d;
    rec_r.name_length    = kept_d;
    rec_r.last_of_run    = 1'b1;

    end_r                = '0;
    end_r.kind           = KIND_END;
    end_r.network_ident  = net_d;
    end_r.stream_ident   = stream_d;
    end_r.service_count  = count_q;
    end_r.last_of_run    = 1'b1;

    pair_o.v0 = name_emit | rec_emit | end_emit;
    pair_o.r0 = name_emit ? name_r : (rec_emit ? rec_r : end_r);
    pair_o.v1 = name_emit & rec_emit;
    pair_o.r1 = rec_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      dropping_q <= 1'b1;
      pos_q      <= '0;
      seclen_q   <= '0;
      loop_q     <= '0;
      off_q      <= '0;
      dlen_q     <= '0;
      tag_q      <= '0;
      prov_q     <= '0;
      svc_q      <= '0;
      net_q      <= '0;
      stream_q   <= '0;
      kind_q     <= '0;
      kept_q     <= '0;
      count_q    <= '0;
      pend_q     <= '0;
      hsvc_q     <= '0;
      target_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      dropping_q <= dropping_d;
      pos_q      <= pos_d;
      seclen_q   <= seclen_d;
      loop_q     <= loop_d;
      off_q      <= off_d;
      dlen_q     <= dlen_d;
      tag_q      <= tag_d;
      prov_q     <= prov_d;
      svc_q      <= svc_d;
      net_q      <= net_d;
      stream_q   <= stream_d;
      kind_q     <= kind_d;
      kept_q     <= kept_d;
      count_q    <= count_d;
      pend_q     <= pend_d;
      hsvc_q     <= hsvc_d;
      target_q   <= target_d;
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_o.v1 |-> (pair_o.v0 && pair_o.r0.kind == KIND_NAME &&
                   pair_o.r1.kind == KIND_RECORD))
    else $error("second result without name byte first");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |-> !pair_o.v0)
    else $error("result without a transaction");

  a_kept_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= NAME_CAP)
    else $error("kept name length above cap");

endmodule

### rtl/sdtp_res_fifo.sv
module sdtp_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sdtp_pkg::result_pair_t pair_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sdtp_pkg::result_t      out_o
);
  import sdtp_pkg::*;

  result_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nx;
  logic [FIFO_CNT_W-1:0]   push_n;
  logic                    pop;

  assign wr_ptr_nx   = wr_ptr_q + FIFO_PTR_W'(1);
  assign push_n      = FIFO_CNT_W'(pair_i.v0) + FIFO_CNT_W'(pair_i.v1);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_o       = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_n);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + push_n - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.v0) begin
      mem_q[wr_ptr_q] <= pair_i.r0;
    end
    if (pair_i.v1) begin
      mem_q[wr_ptr_nx] <= pair_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.v0 |-> room_o)
    else $error("push into result queue without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdtp_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int REPORT_MAX    = 10;

  localparam logic [7:0] SVC_TYPE_TV         = 8'h01;
  localparam logic [7:0] SVC_TYPE_RADIO      = 8'h02;
  localparam logic [7:0] SVC_TYPE_BROADCAST  = 8'h0c;
  localparam logic [7:0] SVC_TYPE_NVOD_REF   = 8'h04;
  localparam logic [7:0] SVC_TYPE_NVOD_SHIFT = 8'h05;

  localparam logic [2:0] KC_NONE       = 3'd0;
  localparam logic [2:0] KC_TV         = 3'd1;
  localparam logic [2:0] KC_RADIO      = 3'd2;
  localparam logic [2:0] KC_BROADCAST  = 3'd3;
  localparam logic [2:0] KC_NVOD_REF   = 3'd4;
  localparam logic [2:0] KC_NVOD_SHIFT = 3'd5;

  class sdt_result_tracker;
    logic [7:0]  tid;
    logic [5:0]  name_lim;
    logic [11:0] pos;
    logic [11:0] sec_len;
    phase_e      phase;
    logic        drop;
    logic [11:0] loop_left;
    logic [7:0]  d_off;
    logic [7:0]  d_len;
    logic [7:0]  d_tag;
    logic [7:0]  prov_len;
    logic [7:0]  svc_count;
    logic [15:0] svc_id;
    logic [15:0] net_id;
    logic [15:0] ts_id;
    logic [15:0] ts_pending;
    logic [15:0] hdr_svc;
    logic [2:0]  svc_kind;
    logic [5:0]  kept;
    logic [5:0]  target;
    result_t     awaited[$];
    int          fail_count;

    function new();
      tid        = DEFAULT_TID;
      name_lim   = NAME_CAP;
      pos        = '0;
      sec_len    = '0;
      phase      = PH_IDLE;
      drop       = 1'b1;
      loop_left  = '0;
      d_off      = '0;
      d_len      = '0;
      d_tag      = '0;
      prov_len   = '0;
      svc_count  = '0;
      svc_id     = '0;
      net_id     = '0;
      ts_id      = '0;
      ts_pending = '0;
      hdr_svc    = '0;
      svc_kind   = '0;
      kept       = '0;
      target     = '0;
      fail_count = 0;
    endfunction

    function void configure(input logic idx, input logic [7:0] value);
      if (idx == CFG_TID) begin
        tid = value;
      end else begin
        name_lim = value[5:0];
      end
    endfunction

    function logic [2:0] svc_code(input logic [7:0] t);
      case (t)
        SVC_TYPE_TV:         return KC_TV;
        SVC_TYPE_RADIO:      return KC_RADIO;
        SVC_TYPE_BROADCAST:  return KC_BROADCAST;
        SVC_TYPE_NVOD_REF:   return KC_NVOD_REF;
        SVC_TYPE_NVOD_SHIFT: return KC_NVOD_SHIFT;
        default:             return KC_NONE;
      endcase
    endfunction

    function void add_result(input result_kind_e kind, input logic [15:0] sid,
                             input logic [2:0] kc, input logic [7:0] tag,
                             input logic [7:0] ch, input logic [5:0] nl,
                             input logic [7:0] cnt);
      result_t r;
      r.kind          = kind;
      r.service_ident = sid;
      r.network_ident = net_id;
      r.stream_ident  = ts_id;
      r.kind_code     = kc;
      r.tag_seen      = tag;
      r.name_char     = ch;
      r.name_length   = nl;
      r.service_count = cnt;
      r.last_of_run   = 1'b0;
      awaited.push_back(r);
    endfunction

    function void close_section();
      add_result(KIND_END, '0, '0, '0, '0, '0, svc_count);
      phase = PH_IDLE;
      drop  = 1'b1;
    endfunction

    function void close_descriptor();
      add_result(KIND_RECORD, svc_id, svc_kind, d_tag, '0, kept, '0);
      d_off = '0;
      phase = (loop_left == 0) ? PH_SVC : PH_DTAG;
    endfunction

    function void parse_body(input logic [7:0] b);
      int o;
      int lim;
      case (phase)
        PH_HEADER: begin
          case (pos)
            12'd0: ts_pending = {b, 8'h00};
            12'd1: ts_pending = ts_pending | b;
            12'd3: if (b == 8'h00) ts_id = ts_pending;
            12'd5: net_id = {b, 8'h00};
            12'd6: net_id = net_id | b;
            12'd7: begin
              phase = PH_SVC;
              d_off = '0;
            end
            default: ;
          endcase
        end
        PH_SVC: begin
          if (d_off == 0) begin
            hdr_svc  = {b, 8'h00};
            svc_id   = '0;
            svc_kind = '0;
            kept     = '0;
            target   = '0;
          end else if (d_off == 1) begin
            hdr_svc = hdr_svc | b;
          end else if (d_off == 3) begin
            loop_left = {b[3:0], 8'h00};
          end else if (d_off == 4) begin
            loop_left = loop_left | b;
          end
          d_off = d_off + 1;
          if (d_off >= 5) begin
            d_off = '0;
            phase = (loop_left == 0) ? PH_SVC : PH_DTAG;
          end
        end
        PH_DTAG: begin
          if (loop_left != 0) loop_left = loop_left - 1;
          d_tag = b;
          if (b == TAG_SERVICE) begin
            svc_id   = hdr_svc;
            svc_kind = '0;
            kept     = '0;
            target   = '0;
            prov_len = '0;
            if (svc_count != 8'hFF) svc_count = svc_count + 1;
          end
          phase = PH_DLEN;
        end
        PH_DLEN: begin
          if (loop_left != 0) loop_left = loop_left - 1;
          d_len = b;
          d_off = '0;
          if (b == 8'h00) begin
            close_descriptor();
          end else begin
            phase = PH_DBODY;
          end
        end
        PH_DBODY: begin
          o = int'(d_off);
          if (loop_left != 0) loop_left = loop_left - 1;
          if (d_tag == TAG_SERVICE) begin
            lim = (name_lim > NAME_CAP) ? int'(NAME_CAP) : int'(name_lim);
            if (o == 0) begin
              svc_kind = svc_code(b);
            end else if (o == 1) begin
              prov_len = b;
            end else if (o == 2 + int'(prov_len)) begin
              target = (int'(b) < lim) ? b[5:0] : lim[5:0];
            end else if (o > 2 + int'(prov_len) && kept < target) begin
              kept = kept + 1;
              add_result(KIND_NAME, svc_id, svc_kind, TAG_SERVICE, b, kept, '0);
            end
          end
          d_off = 8'(o + 1);
          if (o + 1 >= int'(d_len)) close_descriptor();
        end
        default: begin
          phase = PH_IDLE;
          drop  = 1'b1;
        end
      endcase
    endfunction

    function void note_byte(input logic [7:0] b, input logic start);
      int n_before;
      int k;
      int len;
      n_before = awaited.size();
      if (start) begin
        if (b == tid) begin
          drop      = 1'b0;
          phase     = PH_LEN_HI;
          pos       = '0;
          sec_len   = '0;
          svc_count = '0;
          net_id    = '0;
          loop_left = '0;
          d_off     = '0;
        end else begin
          drop  = 1'b1;
          phase = PH_IDLE;
        end
      end else if (!drop) begin
        if (phase == PH_LEN_HI) begin
          sec_len = {b[3:0], 8'h00};
          phase   = PH_LEN_LO;
        end else if (phase == PH_LEN_LO) begin
          sec_len = sec_len | b;
          pos     = '0;
          if (sec_len == 0) begin
            close_section();
          end else begin
            phase = PH_HEADER;
          end
        end else begin
          k   = int'(pos);
          len = int'(sec_len);
          if (k >= len - 1) begin
            close_section();
          end else if (k < len - 4) begin
            parse_body(b);
          end
          pos = pos + 1;
        end
      end
      if (awaited.size() > n_before) awaited[awaited.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("unexpected result %h at %0t", got, $time);
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind || got.service_ident != want.service_ident ||
          got.network_ident != want.network_ident ||
          got.stream_ident != want.stream_ident || got.kind_code != want.kind_code ||
          got.tag_seen != want.tag_seen || got.name_char != want.name_char ||
          got.name_length != want.name_length ||
          got.service_count != want.service_count ||
          got.last_of_run != want.last_of_run) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("result mismatch at %0t: expected %h, got %h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  section_byte_i = 8'h00;
  logic        first_byte_i   = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = CFG_TID;
  logic [7:0]  cfg_data_i     = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  result_kind_o;
  logic [15:0] service_ident_o;
  logic [15:0] network_ident_o;
  logic [15:0] stream_ident_o;
  logic [2:0]  kind_code_o;
  logic [7:0]  tag_seen_o;
  logic [7:0]  name_char_o;
  logic [5:0]  name_length_o;
  logic [7:0]  service_count_o;
  logic        last_of_run_o;

  sdt_result_tracker tracker = new();
  result_t     seen;
  logic [8:0]  stream[$];
  logic [7:0]  live_tid = DEFAULT_TID;
  int          counted;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  logic [7:0]  phase_ids[6];
  logic [7:0]  phase_limits[6];

  sdt_service_descriptor_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .section_byte_i  (section_byte_i),
    .first_byte_i    (first_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .service_ident_o (service_ident_o),
    .network_ident_o (network_ident_o),
    .stream_ident_o  (stream_ident_o),
    .kind_code_o     (kind_code_o),
    .tag_seen_o      (tag_seen_o),
    .name_char_o     (name_char_o),
    .name_length_o   (name_length_o),
    .service_count_o (service_count_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.note_byte(section_byte_i, first_byte_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {result_kind_o, service_ident_o, network_ident_o, stream_ident_o, kind_code_o,
              tag_seen_o, name_char_o, name_length_o, service_count_o, last_of_run_o};
      tracker.check_result(seen);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    section_byte_i <= b;
    first_byte_i   <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_stream();
    foreach (stream[i]) push_byte(stream[i][7:0], stream[i][8]);
    stream.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] id, input logic [7:0] lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TID;
    cfg_data_i <= id;
    @(posedge clk_i);
    tracker.configure(CFG_TID, id);
    cfg_idx_i  <= CFG_NAME_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    tracker.configure(CFG_NAME_LIMIT, lim);
    cfg_we_i <= 1'b0;
    live_tid = id;
  endtask

  // wrap a service loop in table id, length, header and four random CRC bytes; keep < 0 sends all of it
  task automatic frame_section(input logic [7:0] id, input logic [11:0] len,
                               ref logic [7:0] body_q[$], input int keep);
    logic [8:0]  sec_q[$];
    logic [15:0] tsid;
    logic [15:0] onid;
    int          n_emit;
    tsid = 16'($urandom);
    onid = 16'($urandom);
    sec_q.push_back({1'b1, id});
    sec_q.push_back({1'b0, 4'($urandom_range(15)), len[11:8]});
    sec_q.push_back({1'b0, len[7:0]});
    sec_q.push_back({1'b0, tsid[15:8]});
    sec_q.push_back({1'b0, tsid[7:0]});
    sec_q.push_back({1'b0, 8'($urandom)});
    sec_q.push_back({1'b0, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom)});
    sec_q.push_back({1'b0, 8'($urandom)});
    sec_q.push_back({1'b0, onid[15:8]});
    sec_q.push_back({1'b0, onid[7:0]});
    sec_q.push_back({1'b0, 8'($urandom)});
    foreach (body_q[i]) sec_q.push_back({1'b0, body_q[i]});
    repeat (4) sec_q.push_back({1'b0, 8'($urandom)});
    n_emit = (keep < 0 || keep > sec_q.size()) ? sec_q.size() : keep;
    for (int i = 0; i < n_emit; i++) stream.push_back(sec_q[i]);
    if (id == live_tid) counted += n_emit;
  endtask

  task automatic build_section(input logic [7:0] id, input bit broken);
    logic [7:0]  body_q[$];
    logic [7:0]  loop_q[$];
    logic [7:0]  desc_q[$];
    logic [7:0]  svc_types[6];
    logic [15:0] sid;
    logic [11:0] loop_len;
    logic [11:0] len;
    int          plen;
    int          nlen;
    int          nbytes;
    int          dlen;
    int          keep;
    svc_types = '{SVC_TYPE_TV, SVC_TYPE_RADIO, SVC_TYPE_BROADCAST, SVC_TYPE_NVOD_REF,
                  SVC_TYPE_NVOD_SHIFT, 8'($urandom)};
    repeat ($urandom_range(0, 3)) begin
      loop_q.delete();
      repeat ($urandom_range(0, 3)) begin
        desc_q.delete();
        if ($urandom_range(99) < 65) begin
          plen   = $urandom_range(0, 3);
          nlen   = ($urandom_range(99) < 10) ? $urandom_range(0, 255) : $urandom_range(0, 12);
          nbytes = (nlen > 60) ? $urandom_range(0, 60) : nlen;
          if ($urandom_range(99) < 15) nbytes = $urandom_range(0, nbytes);
          desc_q.push_back(svc_types[$urandom_range(0, 5)]);
          desc_q.push_back(8'(plen));
          repeat (plen) desc_q.push_back(8'($urandom));
          desc_q.push_back(8'(nlen));
          repeat (nbytes) desc_q.push_back(8'($urandom));
          dlen = desc_q.size();
          // truncate the descriptor now and then
          if ($urandom_range(99) < 10) dlen = $urandom_range(0, dlen);
          loop_q.push_back(TAG_SERVICE);
        end else begin
          dlen = $urandom_range(0, 6);
          repeat (dlen) desc_q.push_back(8'($urandom));
          loop_q.push_back(8'($urandom));
        end
        loop_q.push_back(8'(dlen));
        for (int i = 0; i < dlen; i++) loop_q.push_back(desc_q[i]);
      end
      loop_len = 12'(loop_q.size());
      if ($urandom_range(99) < 8) loop_len = 12'($urandom_range(0, loop_q.size() + 4));
      sid = 16'($urandom);
      body_q.push_back(sid[15:8]);
      body_q.push_back(sid[7:0]);
      body_q.push_back(8'($urandom));
      body_q.push_back({4'($urandom_range(15)), loop_len[11:8]});
      body_q.push_back(loop_len[7:0]);
      foreach (loop_q[i]) body_q.push_back(loop_q[i]);
    end
    len  = 12'(8 + body_q.size() + 4);
    keep = -1;
    if (broken) begin
      len = 12'($urandom_range(0, int'(len) + 8));
      if ($urandom_range(1) == 1) keep = $urandom_range(1, body_q.size() + 15);
    end
    frame_section(id, len, body_q, keep);
  endtask

  // more than 255 service descriptors: the section count saturates
  task automatic build_crowded_section(input logic [7:0] id);
    logic [7:0] body_q[$];
    body_q.push_back(8'($urandom));
    body_q.push_back(8'($urandom));
    body_q.push_back(8'($urandom));
    body_q.push_back({4'($urandom_range(15)), 4'h2});
    body_q.push_back(8'h08);
    repeat (260) begin
      body_q.push_back(TAG_SERVICE);
      body_q.push_back(8'h00);
    end
    frame_section(id, 12'd537, body_q, -1);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8)) begin
      stream.push_back({($urandom_range(99) < 20) ? 1'b1 : 1'b0,
                        ($urandom_range(99) < 30) ? live_tid : 8'($urandom)});
    end
  endtask

  initial begin
    int pick;
    send_idle_pct = 24;
    recv_idle_pct = 61;
    phase_ids     = '{DEFAULT_TID, 8'h00, 8'hFF, 8'($urandom), DEFAULT_TID,
                      DEFAULT_TID};
    phase_limits  = '{8'd50, 8'd0, 8'hFF, 8'd7, 8'($urandom_range(1, 50)), 8'd1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length, foreign table id, restart inside a section, section short of its header
    stream = '{9'h142, 9'h0F0, 9'h000,
               9'h143, 9'h000, 9'h0FF, 9'h1FF,
               9'h142, 9'h000, 9'h020, 9'h012,
               9'h142, 9'h000, 9'h002, 9'h0FF, 9'h000};
    send_stream();
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 24 : (p < 4) ? 61 : 0;
      recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 24 : 0;
      program_regs(phase_ids[p], phase_limits[p]);
      counted = 0;
      if (p == 4) begin
        build_crowded_section(live_tid);
        send_stream();
      end
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          build_section(live_tid, 1'b0);
        end else if (pick < 80) begin
          build_section(live_tid, 1'b1);
        end else if (pick < 88) begin
          build_section(live_tid ^ 8'($urandom_range(1, 255)), 1'b0);
        end else begin
          add_noise();
        end
        send_stream();
      end
      drain();
    end

    if (tracker.fail_count == 0 && tracker.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
